// ===== design/tsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrc_pkg
// Shared types and constants for the thermal sensor reading converter:
// register map, formula modes, reset values and pipeline dimensions.
// ----------------------------------------------------------------------------
package tsrc_pkg;

    localparam int unsigned REG_COUNT  = 8;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 32;

    typedef enum logic [2:0] {
        REG_FORMULA_MODE   = 3'd0,
        REG_FIELD_SHIFT    = 3'd1,
        REG_FIELD_MASK     = 3'd2,
        REG_VALID_CHECK_EN = 3'd3,
        REG_VALID_SHIFT    = 3'd4,
        REG_OFFSET_B       = 3'd5,
        REG_SLOPE_M        = 3'd6,
        REG_DIVISOR        = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_B_MINUS_MC = 2'd0,
        MODE_MC_MINUS_B = 2'd1,
        MODE_SIGNED10   = 2'd2,
        MODE_ALIAS_0    = 2'd3
    } formula_mode_t;

    localparam logic [1:0]  RST_FORMULA_MODE = MODE_B_MINUS_MC;
    localparam logic [4:0]  RST_FIELD_SHIFT  = 5'd10;
    localparam logic [31:0] RST_FIELD_MASK   = 32'd511;
    localparam logic        RST_VALID_CHECK  = 1'b0;
    localparam logic [4:0]  RST_VALID_SHIFT  = 5'd9;
    localparam logic [31:0] RST_OFFSET_B     = 32'd3153000000;
    localparam logic [31:0] RST_SLOPE_M      = 32'd10000000;
    localparam logic [15:0] RST_DIVISOR      = 16'd13825;

    localparam logic [31:0] CODE_NEG_LIMIT   = 32'd512;
    localparam logic [31:0] CODE_WRAP        = 32'd1024;

    localparam logic [31:0] SAT_POS          = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG          = 32'h8000_0000;

    localparam logic        STATUS_OK        = 1'b0;
    localparam logic        STATUS_INVALID   = 1'b1;

    // stage map: extract, multiply, add, divide prep, divide stages, output
    localparam int unsigned DIV_STAGES       = 8;
    localparam int unsigned DIV_BITS         = 4;
    localparam int unsigned ST_EXT           = 0;
    localparam int unsigned ST_MUL           = 1;
    localparam int unsigned ST_ADD           = 2;
    localparam int unsigned ST_PREP          = 3;
    localparam int unsigned ST_DIV0          = 4;
    localparam int unsigned ST_OUT           = ST_DIV0 + DIV_STAGES;
    localparam int unsigned NSTAGE           = ST_OUT + 1;

endpackage

// ===== design/thermal_sensor_reading_convert.sv =====
// ----------------------------------------------------------------------------
// thermal_sensor_reading_convert
// Converts a raw sensor status word to millidegrees Celsius through a
// thirteen-stage pipeline with an APB-style register port.
// ----------------------------------------------------------------------------
//  channel | ports                         | beat
//  --------+-------------------------------+---------------------------------
//  input   | s_valid s_ready s_raw_word    | one raw status word
//  result  | m_valid m_ready m_status      | status and saturated temperature
//          | m_millidegrees                |
//  config  | psel penable pwrite paddr ... | one register write or read
//
//  One beat per cycle while the result side is not stalled.
//  Stages: extract, 32x32 multiply, 64-bit add, divide prep, eight divide
//  stages of four quotient bits each, saturate into the output register.
//  Each stage advances when its successor is empty or advancing; bubbles
//  collapse, and a stalled result holds back the input only once every
//  stage is full.
//  Reset clears the valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module thermal_sensor_reading_convert (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_raw_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic signed [31:0] m_millidegrees
);
    import tsrc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [1:0]  formula_mode_reg;
    logic [4:0]  field_shift_reg;
    logic [31:0] field_mask_reg;
    logic        valid_check_reg;
    logic [4:0]  valid_shift_reg;
    logic [31:0] offset_b_reg;
    logic [31:0] slope_m_reg;
    logic [15:0] divisor_reg;

    reg_idx_t    reg_idx;
    logic        cfg_wr;
    logic [15:0] div_eff;

    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign div_eff = (divisor_reg == 16'd0) ? 16'd1 : divisor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            formula_mode_reg <= RST_FORMULA_MODE;
            field_shift_reg  <= RST_FIELD_SHIFT;
            field_mask_reg   <= RST_FIELD_MASK;
            valid_check_reg  <= RST_VALID_CHECK;
            valid_shift_reg  <= RST_VALID_SHIFT;
            offset_b_reg     <= RST_OFFSET_B;
            slope_m_reg      <= RST_SLOPE_M;
            divisor_reg      <= RST_DIVISOR;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FORMULA_MODE:   formula_mode_reg <= pwdata[1:0];
                REG_FIELD_SHIFT:    field_shift_reg  <= pwdata[4:0];
                REG_FIELD_MASK:     field_mask_reg   <= pwdata;
                REG_VALID_CHECK_EN: valid_check_reg  <= pwdata[0];
                REG_VALID_SHIFT:    valid_shift_reg  <= pwdata[4:0];
                REG_OFFSET_B:       offset_b_reg     <= pwdata;
                REG_SLOPE_M:        slope_m_reg      <= pwdata;
                REG_DIVISOR:        divisor_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FORMULA_MODE:   prdata = {30'd0, formula_mode_reg};
            REG_FIELD_SHIFT:    prdata = {27'd0, field_shift_reg};
            REG_FIELD_MASK:     prdata = field_mask_reg;
            REG_VALID_CHECK_EN: prdata = {31'd0, valid_check_reg};
            REG_VALID_SHIFT:    prdata = {27'd0, valid_shift_reg};
            REG_OFFSET_B:       prdata = offset_b_reg;
            REG_SLOPE_M:        prdata = slope_m_reg;
            REG_DIVISOR:        prdata = {16'd0, divisor_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] rdy;

    always_comb begin
        rdy[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[ST_EXT];
    assign m_valid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[ST_EXT]) begin
                vld_reg[ST_EXT] <= s_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage: extract ----------------
    logic        ext_inv_next,  ext_inv_reg;
    logic        ext_neg_next,  ext_neg_reg;
    logic [31:0] ext_cmag_next, ext_cmag_reg;
    logic [31:0] ext_code;
    logic [31:0] ext_vword;

    always_comb begin
        ext_vword     = s_raw_word >> valid_shift_reg;
        ext_inv_next  = valid_check_reg && !ext_vword[0];
        ext_code      = (s_raw_word >> field_shift_reg) & field_mask_reg;
        ext_neg_next  = 1'b0;
        ext_cmag_next = ext_code;
        if (formula_mode_reg == MODE_SIGNED10 && ext_code >= CODE_NEG_LIMIT) begin
            if (ext_code >= CODE_WRAP) begin
                ext_cmag_next = ext_code - CODE_WRAP;
            end else begin
                ext_neg_next  = 1'b1;
                ext_cmag_next = CODE_WRAP - ext_code;
            end
        end
    end

    // ---------------- stage: multiply ----------------
    logic        mul_inv_reg;
    logic        mul_neg_reg;
    logic [63:0] mul_prod_next, mul_prod_reg;

    assign mul_prod_next = 64'(slope_m_reg) * 64'(ext_cmag_reg);

    // ---------------- stage: signed add ----------------
    logic        add_inv_reg;
    logic        add_nr_next,  add_nr_reg;
    logic [63:0] add_mag_next, add_mag_reg;
    logic [63:0] add_p, add_n;
    logic [64:0] add_pn, add_np;
    logic        add_sum;

    always_comb begin
        add_sum = 1'b0;
        add_p   = {32'd0, offset_b_reg};
        add_n   = mul_prod_reg;
        case (formula_mode_reg)
            MODE_MC_MINUS_B: begin
                add_p = mul_prod_reg;
                add_n = {32'd0, offset_b_reg};
            end
            MODE_SIGNED10: begin
                add_sum = !mul_neg_reg;
            end
            default: ;
        endcase
        add_pn = {1'b0, add_p} - {1'b0, add_n};
        add_np = {1'b0, add_n} - {1'b0, add_p};
        if (add_sum) begin
            add_nr_next  = 1'b0;
            add_mag_next = mul_prod_reg + {32'd0, offset_b_reg};
        end else if (add_pn[64]) begin
            add_nr_next  = 1'b1;
            add_mag_next = add_np[63:0];
        end else begin
            add_nr_next  = 1'b0;
            add_mag_next = add_pn[63:0];
        end
    end

    // ---------------- stage: divide prep ----------------
    logic        prep_inv_reg;
    logic        prep_nr_reg;
    logic        prep_sat_next, prep_sat_reg;
    logic [15:0] prep_rem_reg;
    logic [31:0] prep_q_reg;

    assign prep_sat_next = add_mag_reg[63:32] >= {16'd0, div_eff};

    // ---------------- stages: divide ----------------
    function automatic logic [47:0] div_step(input logic [47:0] rq, input logic [15:0] d);
        logic [16:0] r;
        logic [31:0] q;
        r = {rq[47:32], rq[31]};
        q = {rq[30:0], 1'b0};
        if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[0] = 1'b1;
        end
        return {r[15:0], q};
    endfunction

    logic        div_inv_reg [DIV_STAGES];
    logic        div_nr_reg  [DIV_STAGES];
    logic        div_sat_reg [DIV_STAGES];
    logic [47:0] div_rq_reg  [DIV_STAGES];
    logic [47:0] div_rq_next [DIV_STAGES];

    always_comb begin
        div_rq_next[0] = {prep_rem_reg, prep_q_reg};
        for (int s = 1; s < DIV_STAGES; s++) begin
            div_rq_next[s] = div_rq_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int b = 0; b < DIV_BITS; b++) begin
                div_rq_next[s] = div_step(div_rq_next[s], div_eff);
            end
        end
    end

    // ---------------- stage: saturate and output ----------------
    logic        out_status_next, out_status_reg;
    logic [31:0] out_md_next,     out_md_reg;
    logic [31:0] out_q;

    always_comb begin
        out_q           = div_rq_reg[DIV_STAGES-1][31:0];
        out_status_next = STATUS_OK;
        if (div_inv_reg[DIV_STAGES-1]) begin
            out_status_next = STATUS_INVALID;
            out_md_next     = '0;
        end else if (div_nr_reg[DIV_STAGES-1]) begin
            if (div_sat_reg[DIV_STAGES-1] || out_q > SAT_NEG) begin
                out_md_next = SAT_NEG;
            end else begin
                out_md_next = 32'd0 - out_q;
            end
        end else begin
            if (div_sat_reg[DIV_STAGES-1] || out_q[31]) begin
                out_md_next = SAT_POS;
            end else begin
                out_md_next = out_q;
            end
        end
    end

    assign m_status       = out_status_reg;
    assign m_millidegrees = signed'(out_md_reg);

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (rdy[ST_EXT]) begin
            ext_inv_reg  <= ext_inv_next;
            ext_neg_reg  <= ext_neg_next;
            ext_cmag_reg <= ext_cmag_next;
        end
        if (rdy[ST_MUL]) begin
            mul_inv_reg  <= ext_inv_reg;
            mul_neg_reg  <= ext_neg_reg;
            mul_prod_reg <= mul_prod_next;
        end
        if (rdy[ST_ADD]) begin
            add_inv_reg <= mul_inv_reg;
            add_nr_reg  <= add_nr_next;
            add_mag_reg <= add_mag_next;
        end
        if (rdy[ST_PREP]) begin
            prep_inv_reg <= add_inv_reg;
            prep_nr_reg  <= add_nr_reg;
            prep_sat_reg <= prep_sat_next;
            prep_rem_reg <= add_mag_reg[47:32];
            prep_q_reg   <= add_mag_reg[31:0];
        end
        if (rdy[ST_DIV0]) begin
            div_inv_reg[0] <= prep_inv_reg;
            div_nr_reg[0]  <= prep_nr_reg;
            div_sat_reg[0] <= prep_sat_reg;
            div_rq_reg[0]  <= div_rq_next[0];
        end
        for (int s = 1; s < DIV_STAGES; s++) begin
            if (rdy[ST_DIV0 + s]) begin
                div_inv_reg[s] <= div_inv_reg[s-1];
                div_nr_reg[s]  <= div_nr_reg[s-1];
                div_sat_reg[s] <= div_sat_reg[s-1];
                div_rq_reg[s]  <= div_rq_next[s];
            end
        end
        if (rdy[ST_OUT]) begin
            out_status_reg <= out_status_next;
            out_md_reg     <= out_md_next;
        end
    end

endmodule

// ===== design/tsrc_checker.sv =====
// ----------------------------------------------------------------------------
// tsrc_checker
// Port-level checks on the converter's result channel and flow control,
// bound to the top level.
// ----------------------------------------------------------------------------
module tsrc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_status,
    input logic signed [31:0] m_millidegrees
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present straight after reset");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_millidegrees == 32'sd0))
        else $error("invalid reading carries a non-zero temperature");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_status) && $stable(m_millidegrees)))
        else $error("stalled result beat changed or dropped");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input held off while the result side can advance");

endmodule

bind thermal_sensor_reading_convert tsrc_checker u_tsrc_checker (.*);
